// File: rtl/iou_track_associator_assert.svh
`ifndef IOU_TRACK_ASSOCIATOR_ASSERT_SVH
`define IOU_TRACK_ASSOCIATOR_ASSERT_SVH
// assertion helpers
`define IOU_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: lbl failed");
`define IOU_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: lbl failed");
`endif

// File: rtl/iou_pkg.sv
package iou_pkg;
    localparam int NUM_STREAMS = 4;
    localparam int TABLE_DEPTH = 64;
    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int KW = $clog2(TABLE_DEPTH);
    localparam int CW = KW + 1;

    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [7:0]         cls;
        logic [15:0]        id;
        logic               vld;
    } trk_t;

    // shift control for the cell chain
    typedef struct packed {
        logic       rot;
        logic       wr;
        logic [KW-1:0] wr_k;
        trk_t       wdat;
    } chain_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_M1, ST_M2, ST_DEC, ST_OUT
    } state_t;
endpackage

// File: rtl/iou_cell.sv
module iou_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rot,
    input  logic          ld,
    input  iou_pkg::trk_t ld_dat,
    input  iou_pkg::trk_t prev,
    output iou_pkg::trk_t cur
);
    import iou_pkg::*;
    trk_t t_reg, t_next;

    always_comb
    begin
        t_next = t_reg;
        if (ld)
            t_next = ld_dat;
        else if (rot)
            t_next = prev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else
            t_reg <= t_next;
    end

    assign cur = t_reg;
endmodule

// File: rtl/iou_chain.sv
// one ring per stream; cell 0 is the scan head
module iou_chain
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [iou_pkg::SW-1:0] sel,
    input  iou_pkg::chain_ctl_t    ctl,
    output iou_pkg::trk_t          head
);
    import iou_pkg::*;
    trk_t cells [NUM_STREAMS][TABLE_DEPTH];

    for (genvar s = 0; s < NUM_STREAMS; s++) begin : g_s
        for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_k
            logic ld;
            // the ring always ends a request at its home position
            assign ld = (sel == SW'(s)) && ctl.wr && (ctl.wr_k == KW'(k));
            iou_cell u_cell
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .rot    (ctl.rot && (sel == SW'(s))),
                .ld     (ld),
                .ld_dat (ctl.wdat),
                .prev   (cells[s][(k + 1) % TABLE_DEPTH]),
                .cur    (cells[s][k])
            );
        end
    end

    assign head = cells[sel][0];
endmodule

// File: rtl/iou_track_associator.sv
// the answer is valid after the ring scan and the match stages M1 and M2 once a request is taken,
// or straight after the scan state when the slot is new or the stream is bad and the scan is skipped
// one request is handled at a time, and out_stall can hold the answer and the next request
// during the scan the per-stream ring of track cells turns once per cycle past the scoring head
// the answer is held until taken and no new request is accepted before then
// reset clears all tracks, counts and sets id counters to all ones
module iou_track_associator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  stream,
    input  logic [5:0]  slot,
    input  logic [7:0]  class_id,
    input  logic signed [12:0] box_x,
    input  logic signed [12:0] box_y,
    input  logic [11:0] box_w,
    input  logic [11:0] box_h,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] track_id,
    output logic        matched,
    output logic        table_full
);
    import iou_pkg::*;
    `include "iou_track_associator_assert.svh"

    state_t st_reg, st_next;
    logic [CW-1:0] cnt_reg [NUM_STREAMS];
    logic [15:0]   idc_reg [NUM_STREAMS];
    logic [SW-1:0] s_reg;
    logic [5:0]    slot_reg;
    trk_t          d_reg;
    logic          bad_reg;
    logic [CW-1:0] k_reg, k_next;
    logic [KW-1:0] bk_reg;
    logic [25:0]   bi_reg;
    logic [25:0]   bu_reg;
    logic          fnd_reg;
    logic [15:0]   bid_reg;
    logic [13:0]   iw_reg, ih_reg;
    logic [23:0]   aa_reg, ab_reg;
    logic [25:0]   i_reg, u_reg;
    logic          v1_reg, v2_reg;
    logic [KW-1:0] k1_reg, k2_reg;
    logic [15:0]   id1_reg, id2_reg;
    logic [51:0]   lhs, rhs;
    logic [15:0]   tid_reg;
    logic          mt_reg, tf_reg, ov_reg;
    chain_ctl_t    ctl;
    trk_t          head;
    logic          take, cur_full, slot_new;
    logic [15:0]   nid;
    logic signed [13:0] ax2, bx2, ay2, by2, x1, y1, x2, y2;

    iou_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sel   (s_reg),
        .ctl   (ctl),
        .head  (head)
    );

    assign take     = in_valid && !in_stall;
    assign in_stall = (st_reg != ST_IDLE) || (ov_reg && out_stall);
    assign cur_full = (cnt_reg[s_reg] >= CW'(TABLE_DEPTH));
    assign slot_new = ({1'b0, cnt_reg[s_reg]} <= (CW+1)'(slot_reg));
    assign nid      = idc_reg[s_reg] + 16'd1;

    // overlap of detection and head cell
    always_comb
    begin
        ax2 = 14'(d_reg.x) + $signed({2'b0, d_reg.w});
        bx2 = 14'(head.x) + $signed({2'b0, head.w});
        ay2 = 14'(d_reg.y) + $signed({2'b0, d_reg.h});
        by2 = 14'(head.y) + $signed({2'b0, head.h});
        x1 = (d_reg.x > head.x) ? 14'(d_reg.x) : 14'(head.x);
        y1 = (d_reg.y > head.y) ? 14'(d_reg.y) : 14'(head.y);
        x2 = (ax2 < bx2) ? ax2 : bx2;
        y2 = (ay2 < by2) ? ay2 : by2;
    end

    assign lhs = i_reg * bu_reg;
    assign rhs = bi_reg * u_reg;

    always_comb
    begin
        st_next = st_reg;
        k_next  = k_reg;
        ctl     = '0;
        ctl.wdat = d_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (take)
                    st_next = ST_SCAN;
                k_next = '0;
            end
            ST_SCAN:
            begin
                if (bad_reg || slot_new)
                    st_next = ST_DEC;
                else
                begin
                    ctl.rot = 1'b1;
                    k_next = k_reg + CW'(1);
                    if (k_reg == CW'(TABLE_DEPTH - 1))
                        st_next = ST_M1;
                end
            end
            ST_M1: st_next = ST_M2;
            ST_M2: st_next = ST_DEC;
            ST_DEC:
            begin
                st_next = ST_OUT;
                if (!bad_reg)
                begin
                    if (!slot_new && fnd_reg && ({bi_reg, 1'b0} > {1'b0, bu_reg}))
                    begin
                        ctl.wr = 1'b1;
                        ctl.wr_k = bk_reg;
                        ctl.wdat.id = bid_reg;
                    end
                    else if (!cur_full)
                    begin
                        ctl.wr = 1'b1;
                        ctl.wr_k = cnt_reg[s_reg][KW-1:0];
                        ctl.wdat.id = nid;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            k_reg  <= '0;
            ov_reg <= 1'b0;
            fnd_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                cnt_reg[s] <= '0;
                idc_reg[s] <= 16'hFFFF;
            end
        end
        else
        begin
            st_reg <= st_next;
            k_reg  <= k_next;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (take)
            begin
                s_reg    <= stream[SW-1:0];
                bad_reg  <= (32'(stream) >= NUM_STREAMS);
                slot_reg <= slot;
                d_reg    <= '{x: box_x, y: box_y, w: box_w, h: box_h,
                              cls: class_id, id: 16'd0, vld: 1'b1};
                fnd_reg  <= 1'b0;
                bi_reg   <= '0;
                bu_reg   <= 26'd1;
            end
            // stage 1: widths and areas
            v1_reg  <= (st_reg == ST_SCAN) && !bad_reg && !slot_new && head.vld
                       && (k_reg < cnt_reg[s_reg]) && (head.cls == d_reg.cls);
            iw_reg  <= (x2 > x1) ? 14'(x2 - x1) : '0;
            ih_reg  <= (y2 > y1) ? 14'(y2 - y1) : '0;
            aa_reg  <= d_reg.w * d_reg.h;
            ab_reg  <= head.w * head.h;
            k1_reg  <= k_reg[KW-1:0];
            id1_reg <= head.id;
            // stage 2: intersection and union
            v2_reg  <= v1_reg;
            i_reg   <= 26'(iw_reg * ih_reg);
            u_reg   <= 26'(aa_reg) + 26'(ab_reg) - 26'(iw_reg * ih_reg);
            k2_reg  <= k1_reg;
            id2_reg <= id1_reg;
            // stage 3: keep best, strictly greater
            if (v2_reg && (u_reg != '0) && (lhs > rhs))
            begin
                bi_reg  <= i_reg;
                bu_reg  <= u_reg;
                bk_reg  <= k2_reg;
                bid_reg <= id2_reg;
                fnd_reg <= 1'b1;
            end
            if (st_reg == ST_DEC)
            begin
                ov_reg <= 1'b1;
                if (bad_reg)
                begin
                    tid_reg <= '0; mt_reg <= 1'b0; tf_reg <= 1'b1;
                end
                else if (!slot_new && fnd_reg && ({bi_reg, 1'b0} > {1'b0, bu_reg}))
                begin
                    tid_reg <= bid_reg; mt_reg <= 1'b1; tf_reg <= 1'b0;
                end
                else
                begin
                    tid_reg <= nid; mt_reg <= 1'b0; tf_reg <= cur_full;
                    idc_reg[s_reg] <= nid;
                    if (!cur_full)
                        cnt_reg[s_reg] <= cnt_reg[s_reg] + CW'(1);
                end
            end
        end
    end

    assign out_valid  = ov_reg;
    assign track_id   = tid_reg;
    assign matched    = mt_reg;
    assign table_full = tf_reg;

    `IOU_ASSERT_IMPL(a_busy_stall, st_reg != ST_IDLE, in_stall)
    `IOU_ASSERT_NEXT(a_dec_out, st_reg == ST_DEC, out_valid)
    `IOU_ASSERT_IMPL(a_match_room, out_valid && matched, !table_full)
endmodule
